FILE: design/sse_pkg.sv
// shared types and constants for the scanline sprite evaluator
// used by sse_front, sse_back and scanline_sprite_evaluator_core
package sse_pkg;

    // request type codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_LINE  = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y = 2'd1;

    // field widths
    localparam int unsigned COORD_W  = 12;
    localparam int unsigned WY_W     = 13;
    localparam int unsigned CLIP_W   = 14;
    localparam int unsigned ADDR_W   = 24;
    localparam int unsigned NUMBER_W = 7;

    // queue depths
    localparam int unsigned CMD_DEPTH  = 2;
    localparam int unsigned OUT_DEPTH  = 4;
    localparam int unsigned OUT_CNT_W  = 3;

    typedef struct packed {
        logic        req_type;
        logic [6:0]  entry_index;
        logic [11:0] entry_x;
        logic [11:0] entry_y;
        logic [7:0]  entry_height;
        logic        entry_enable;
        logic [19:0] entry_base;
        logic [9:0]  line_y;
    } t_in_item;

    typedef struct packed {
        logic [23:0] row_address;
        logic [8:0]  screen_start;
        logic [3:0]  pixel_offset;
        logic [4:0]  pixel_count;
        logic [6:0]  sprite_number;
        logic        none_active;
        logic        last;
    } t_out_item;

    // one sprite table entry without its enable bit
    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  height;
        logic [19:0] base;
    } t_sprite;

    // one sprite kept for the current line
    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [COORD_W-1:0]  x;
        logic [NUMBER_W-1:0] number;
    } t_active;

    typedef enum logic {
        CMD_WRITE,
        CMD_LINE
    } t_cmd_kind;

    // classified command from the front to the back
    typedef struct packed {
        t_cmd_kind       kind;
        logic [6:0]      index;
        t_sprite         sprite;
        logic            enable;
        logic [WY_W-1:0] wy;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_NONE
    } t_state;

endpackage

FILE: design/scanline_sprite_evaluator_core.sv
// Scanline sprite evaluator, top level. Front end, back end and result queue.
// A table write is taken by the back end while it is idle. A line request scans
// the table, stopping early once MAX_PER_LINE sprites are kept (one registered
// memory read a cycle), then writes the kept sprites into the result queue while
// it has room, or a single empty-line word when none is kept.
// Reset is synchronous: enable bits clear at once, no clearing pass is needed.
module scanline_sprite_evaluator_core #(
    parameter int unsigned SPRITE_ENTRIES = 128,
    parameter int unsigned MAX_PER_LINE   = 20,
    parameter int unsigned SPRITE_PIXELS  = 16,
    parameter int unsigned LINE_PIXELS    = 320
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  sse_pkg::t_in_item             i_in_item,
    output logic                          empty,
    input  logic                          pop,
    output sse_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sse_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sse_pkg::COORD_W-1:0]   i_cfg_data
);

    logic                          cmd_valid;
    sse_pkg::t_cmd                 cmd;
    logic                          cmd_take;
    logic [sse_pkg::COORD_W-1:0]   scroll_x;
    logic                          out_push;
    sse_pkg::t_out_item            out_item;
    logic [sse_pkg::OUT_CNT_W-1:0] out_count;
    logic                          out_full;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    sse_front #(
        .SPRITE_ENTRIES (SPRITE_ENTRIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_in_item),
        .o_full      (full),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_scroll_x  (scroll_x),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    sse_back #(
        .SPRITE_ENTRIES (SPRITE_ENTRIES),
        .MAX_PER_LINE   (MAX_PER_LINE),
        .SPRITE_PIXELS  (SPRITE_PIXELS),
        .LINE_PIXELS    (LINE_PIXELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_scroll_x  (scroll_x),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out_item  (out_item)
    );

    // result queue toward the consumer
    sse_fifo #(
        .T     (sse_pkg::t_out_item),
        .DEPTH (sse_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_item),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_out_item),
        .o_empty (empty),
        .o_count (out_count)
    );

    // the back end only pushes when a slot is known free
    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> !out_full)
        else $error("result queue overflow");

    // the back end only takes a command while one is queued
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> cmd_valid)
        else $error("command taken from empty queue");

    // a pop without a push lowers the fill count by one
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !out_push) |=> (out_count == $past(out_count) - 1'b1))
        else $error("result queue count mismatch");

endmodule

FILE: design/sse_fifo.sv
// small first-in first-out queue of any packed word type
// depends on nothing
module sse_fifo #(
    parameter type         T     = logic [7:0],
    parameter int unsigned DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  T                             i_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output T                             o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    T              r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    // handshake qualification
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_cnt;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // word storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: design/sse_front.sv
// front end: scroll registers, request classification and command queue
// depends on sse_pkg and sse_fifo
module sse_front #(
    parameter int unsigned SPRITE_ENTRIES = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  sse_pkg::t_in_item                 i_item,
    output logic                              o_full,
    input  logic                              i_cfg_valid,
    input  logic [sse_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sse_pkg::COORD_W-1:0]       i_cfg_data,
    output logic [sse_pkg::COORD_W-1:0]       o_scroll_x,
    output logic                              o_cmd_valid,
    output sse_pkg::t_cmd                     o_cmd,
    input  logic                              i_cmd_take
);

    logic [sse_pkg::COORD_W-1:0] r_scroll_x;
    logic [sse_pkg::COORD_W-1:0] r_scroll_y;
    sse_pkg::t_cmd               cmd;
    logic                        index_ok;
    logic                        enq;
    logic                        q_empty;

    // scroll registers, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_x <= '0;
            r_scroll_y <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sse_pkg::CFG_SCROLL_X: r_scroll_x <= i_cfg_data;
                sse_pkg::CFG_SCROLL_Y: r_scroll_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_scroll_x = r_scroll_x;

    // classify the word and form the world line
    always_comb begin
        index_ok      = (32'(i_item.entry_index) < SPRITE_ENTRIES);
        cmd.kind      = (i_item.req_type == sse_pkg::REQ_LINE) ? sse_pkg::CMD_LINE
                                                               : sse_pkg::CMD_WRITE;
        cmd.index     = i_item.entry_index;
        cmd.sprite.x      = i_item.entry_x;
        cmd.sprite.y      = i_item.entry_y;
        cmd.sprite.height = i_item.entry_height;
        cmd.sprite.base   = i_item.entry_base;
        cmd.enable    = i_item.entry_enable;
        cmd.wy        = sse_pkg::WY_W'(i_item.line_y) + sse_pkg::WY_W'(r_scroll_y);
        // writes beyond the table are accepted and dropped here
        enq = i_push && (cmd.kind == sse_pkg::CMD_LINE || index_ok);
    end

    // command queue toward the back end
    sse_fifo #(
        .T     (sse_pkg::t_cmd),
        .DEPTH (sse_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (enq),
        .i_data  (cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_take),
        .o_data  (o_cmd),
        .o_empty (q_empty),
        .o_count ()
    );

    assign o_cmd_valid = !q_empty;

endmodule

FILE: design/sse_back.sv
// back end: sprite table memory, line scan, active list and result emission
// depends on sse_pkg
module sse_back #(
    parameter int unsigned SPRITE_ENTRIES = 128,
    parameter int unsigned MAX_PER_LINE   = 20,
    parameter int unsigned SPRITE_PIXELS  = 16,
    parameter int unsigned LINE_PIXELS    = 320
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  sse_pkg::t_cmd                     i_cmd,
    output logic                              o_cmd_take,
    input  logic [sse_pkg::COORD_W-1:0]       i_scroll_x,
    input  logic [sse_pkg::OUT_CNT_W-1:0]     i_out_count,
    output logic                              o_out_push,
    output sse_pkg::t_out_item                o_out_item
);

    localparam int unsigned IDX_W = (SPRITE_ENTRIES > 1) ? $clog2(SPRITE_ENTRIES) : 1;
    localparam int unsigned SC_W  = $clog2(SPRITE_ENTRIES + 1);
    localparam int unsigned AI_W  = (MAX_PER_LINE > 1) ? $clog2(MAX_PER_LINE) : 1;
    localparam int unsigned AC_W  = $clog2(MAX_PER_LINE + 1);
    localparam int unsigned CW    = sse_pkg::CLIP_W;

    // sprite table and its reset-cleared enable bits
    sse_pkg::t_sprite r_tbl [SPRITE_ENTRIES];
    logic [SPRITE_ENTRIES-1:0] r_en;

    // active list for the current line
    sse_pkg::t_active r_act [MAX_PER_LINE];

    sse_pkg::t_state         r_state, n_state;
    logic [SC_W-1:0]         r_scan_idx, n_scan_idx;
    logic [AC_W-1:0]         r_count, n_count;
    logic [AC_W-1:0]         r_emit_idx, n_emit_idx;
    logic [sse_pkg::WY_W-1:0] r_wy, n_wy;

    logic                    r_pend;
    logic [IDX_W-1:0]        r_pend_idx;
    sse_pkg::t_sprite        r_rd_sp;
    logic                    r_rd_en;

    logic                    r_ld;
    logic                    r_ld_last;
    sse_pkg::t_active        r_ld_ent;

    logic                    tbl_we;
    logic                    scan_issue;
    logic                    act_we;
    logic                    ld_issue;
    logic                    none_push;
    logic                    hit;
    logic                    room;
    logic [IDX_W-1:0]        wr_addr;
    logic [IDX_W-1:0]        scan_addr;
    logic [sse_pkg::WY_W-1:0] y_end;
    sse_pkg::t_active        act_new;

    logic signed [CW-1:0]    sx;
    logic signed [CW-1:0]    end_s;
    logic signed [CW-1:0]    start_s;
    logic signed [CW-1:0]    off_s;
    logic signed [CW-1:0]    cnt_s;
    sse_pkg::t_out_item      clip_item;

    assign wr_addr   = IDX_W'(i_cmd.index);
    assign scan_addr = r_scan_idx[IDX_W-1:0];

    // cover test on the entry read last cycle
    always_comb begin
        y_end = sse_pkg::WY_W'(r_rd_sp.y) + sse_pkg::WY_W'(r_rd_sp.height);
        hit   = r_pend && r_rd_en
                && (sse_pkg::WY_W'(r_rd_sp.y) <= r_wy) && (r_wy < y_end)
                && (r_count < AC_W'(MAX_PER_LINE));
        act_new.addr   = sse_pkg::ADDR_W'(r_rd_sp.base)
                         + sse_pkg::ADDR_W'(r_wy - sse_pkg::WY_W'(r_rd_sp.y))
                         * sse_pkg::ADDR_W'(SPRITE_PIXELS);
        act_new.x      = r_rd_sp.x;
        act_new.number = sse_pkg::NUMBER_W'(r_pend_idx);
    end

    // result queue has a free slot beyond any load in flight
    assign room = ({1'b0, i_out_count} + (sse_pkg::OUT_CNT_W + 1)'(r_ld))
                  < (sse_pkg::OUT_CNT_W + 1)'(sse_pkg::OUT_DEPTH);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sse_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer: next state and strobes
    always_comb begin
        n_state    = r_state;
        n_scan_idx = r_scan_idx;
        n_count    = r_count;
        n_emit_idx = r_emit_idx;
        n_wy       = r_wy;
        o_cmd_take = 1'b0;
        tbl_we     = 1'b0;
        scan_issue = 1'b0;
        act_we     = 1'b0;
        ld_issue   = 1'b0;
        none_push  = 1'b0;
        unique case (r_state)
            sse_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    if (i_cmd.kind == sse_pkg::CMD_WRITE) begin
                        tbl_we = 1'b1;
                    end else begin
                        n_wy       = i_cmd.wy;
                        n_count    = '0;
                        n_scan_idx = '0;
                        n_state    = sse_pkg::ST_SCAN;
                    end
                end
            end
            sse_pkg::ST_SCAN: begin
                scan_issue = (r_scan_idx < SC_W'(SPRITE_ENTRIES));
                if (scan_issue) begin
                    n_scan_idx = r_scan_idx + 1'b1;
                end
                if (hit) begin
                    act_we  = 1'b1;
                    n_count = r_count + 1'b1;
                end
                if ((r_count == AC_W'(MAX_PER_LINE)) || (!scan_issue && !r_pend)) begin
                    if (r_count == '0) begin
                        n_state = sse_pkg::ST_NONE;
                    end else begin
                        n_emit_idx = r_count - 1'b1;
                        n_state    = sse_pkg::ST_EMIT;
                    end
                end
            end
            sse_pkg::ST_EMIT: begin
                if (room) begin
                    ld_issue = 1'b1;
                    if (r_emit_idx == '0) begin
                        n_state = sse_pkg::ST_IDLE;
                    end else begin
                        n_emit_idx = r_emit_idx - 1'b1;
                    end
                end
            end
            sse_pkg::ST_NONE: begin
                if (room) begin
                    none_push = 1'b1;
                    n_state   = sse_pkg::ST_IDLE;
                end
            end
            default: n_state = sse_pkg::ST_IDLE;
        endcase
    end

    // sequencer datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
            r_ld    <= 1'b0;
        end else begin
            r_count <= n_count;
            r_pend  <= scan_issue;
            r_ld    <= ld_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_idx <= n_scan_idx;
        r_emit_idx <= n_emit_idx;
        r_wy       <= n_wy;
        if (scan_issue) begin
            r_pend_idx <= scan_addr;
        end
    end

    // enable bits clear at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= '0;
        end else if (tbl_we) begin
            r_en[wr_addr] <= i_cmd.enable;
        end
    end

    // sprite table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[wr_addr] <= i_cmd.sprite;
        end
        if (scan_issue) begin
            r_rd_sp <= r_tbl[scan_addr];
            r_rd_en <= r_en[scan_addr];
        end
    end

    // active list write at the fill count, registered read for emission
    always_ff @(posedge i_clk) begin
        if (act_we) begin
            r_act[r_count[AI_W-1:0]] <= act_new;
        end
        if (ld_issue) begin
            r_ld_ent  <= r_act[r_emit_idx[AI_W-1:0]];
            r_ld_last <= (r_emit_idx == '0);
        end
    end

    // horizontal clip of the loaded entry
    always_comb begin
        sx      = $signed(CW'(r_ld_ent.x)) - $signed(CW'(i_scroll_x));
        end_s   = sx + $signed(CW'(SPRITE_PIXELS));
        if (end_s > $signed(CW'(LINE_PIXELS))) begin
            end_s = $signed(CW'(LINE_PIXELS));
        end
        start_s = sx[CW-1] ? '0 : sx;
        off_s   = sx[CW-1] ? -sx : '0;
        cnt_s   = end_s - start_s;
        clip_item.row_address   = r_ld_ent.addr;
        clip_item.sprite_number = r_ld_ent.number;
        clip_item.none_active   = 1'b0;
        clip_item.last          = r_ld_last;
        // wholly off screen
        if (cnt_s <= $signed(CW'(0))) begin
            clip_item.screen_start = '0;
            clip_item.pixel_offset = '0;
            clip_item.pixel_count  = '0;
        end else begin
            clip_item.screen_start = start_s[8:0];
            clip_item.pixel_offset = off_s[3:0];
            clip_item.pixel_count  = cnt_s[4:0];
        end
    end

    // result select: clipped entry or the empty-line word
    always_comb begin
        o_out_push = r_ld || none_push;
        if (r_ld) begin
            o_out_item = clip_item;
        end else begin
            o_out_item             = '0;
            o_out_item.none_active = 1'b1;
            o_out_item.last        = 1'b1;
        end
    end

    // never push into a full result queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> (i_out_count < sse_pkg::OUT_CNT_W'(sse_pkg::OUT_DEPTH)))
        else $error("result pushed into full queue");

    // fill count stays within the per-line limit
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= AC_W'(MAX_PER_LINE))
        else $error("active count over limit");

    // a taken line command starts a scan
    a_line_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_take && i_cmd.kind == sse_pkg::CMD_LINE) |=> (r_state == sse_pkg::ST_SCAN))
        else $error("line command did not start scan");

    // loads only come out of emission
    a_ld_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_issue |-> (r_state == sse_pkg::ST_EMIT) && (r_count != '0))
        else $error("load outside emission");

    // the empty-line word never coincides with a load or a pending scan read
    a_no_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        none_push |-> !r_ld && !r_pend)
        else $error("empty-line word collides with pending work");

endmodule

FILE: tb/scanline_sprite_evaluator_core_test.sv
// self-checking testbench for scanline_sprite_evaluator_core: directed rows, then random phases
// keeps its own sprite table mirror to predict result words; depends on sse_pkg and scanline_sprite_evaluator_core
`timescale 1ns / 100ps

module scanline_sprite_evaluator_core_test;

    localparam int TABLE_DEPTH   = 128;
    localparam int LINE_LIMIT    = 20;
    localparam int SPRITE_W      = 16;
    localparam int SCREEN_W      = 320;
    localparam int SETTLE_CYCLES = 160;
    localparam int HOLD_CYCLES   = 600;
    localparam int STALL_LIMIT   = 3000;

    // register indexes that decode to nothing
    localparam logic [sse_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [sse_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        sse_pkg::t_in_item  req;
        bit                 typed;
        sse_pkg::t_out_item want;
    } t_probe;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          push        = 1'b0;
    logic                          pop         = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic [sse_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [sse_pkg::COORD_W-1:0]   i_cfg_data  = '0;
    sse_pkg::t_in_item             in_word     = '0;
    logic                          full;
    logic                          empty;
    logic                          o_cfg_ready;
    sse_pkg::t_out_item            result_word;

    // mirror of the block state
    sse_pkg::t_sprite              sprite_copy [TABLE_DEPTH];
    logic                          sprite_shown [TABLE_DEPTH];
    logic [sse_pkg::COORD_W-1:0]   scroll_x_copy = '0;
    logic [sse_pkg::COORD_W-1:0]   scroll_y_copy = '0;
    sse_pkg::t_out_item            line_results [$];

    int send_idle_pct = 19;
    int recv_idle_pct = 69;
    bit hold_req      = 1'b0;
    int errors        = 0;
    int n_requests    = 0;
    int n_lines       = 0;
    int n_checked     = 0;
    int n_cfg         = 0;
    int quiet_cycles  = 0;

    scanline_sprite_evaluator_core #(
        .SPRITE_ENTRIES (TABLE_DEPTH),
        .MAX_PER_LINE   (LINE_LIMIT),
        .SPRITE_PIXELS  (SPRITE_W),
        .LINE_PIXELS    (SCREEN_W)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (in_word),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (result_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic note_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    function automatic sse_pkg::t_out_item make_result(input logic [23:0] addr, input int start,
                                                       input int offset, input int count,
                                                       input int number,
                                                       input logic none_flag,
                                                       input logic last_flag);
        sse_pkg::t_out_item w;
        w.row_address   = addr;
        w.screen_start  = 9'(start);
        w.pixel_offset  = 4'(offset);
        w.pixel_count   = 5'(count);
        w.sprite_number = 7'(number);
        w.none_active   = none_flag;
        w.last          = last_flag;
        return w;
    endfunction

    function automatic sse_pkg::t_in_item sprite_write(input int idx, input int x, input int y,
                                                       input int h, input logic en,
                                                       input int base);
        sse_pkg::t_in_item w;
        w              = '0;
        w.req_type     = sse_pkg::REQ_WRITE;
        w.entry_index  = 7'(idx);
        w.entry_x      = 12'(x);
        w.entry_y      = 12'(y);
        w.entry_height = 8'(h);
        w.entry_enable = en;
        w.entry_base   = 20'(base);
        return w;
    endfunction

    function automatic sse_pkg::t_in_item line_request(input int line);
        sse_pkg::t_in_item w;
        w          = '0;
        w.req_type = sse_pkg::REQ_LINE;
        w.line_y   = 10'(line);
        return w;
    endfunction

    function automatic sse_pkg::t_in_item noise_word();
        sse_pkg::t_in_item w;
        w.req_type     = 1'($urandom_range(0, 1));
        w.entry_index  = 7'($urandom_range(0, 127));
        w.entry_x      = 12'($urandom_range(0, 4095));
        w.entry_y      = 12'($urandom_range(0, 4095));
        w.entry_height = 8'($urandom_range(0, 255));
        w.entry_enable = 1'($urandom_range(0, 1));
        w.entry_base   = 20'($urandom_range(0, 20'hFFFFF));
        w.line_y       = 10'($urandom_range(0, 1023));
        return w;
    endfunction

    function automatic t_probe probe(input sse_pkg::t_in_item req, input bit typed,
                                     input sse_pkg::t_out_item want);
        t_probe p;
        p.req   = req;
        p.typed = typed;
        p.want  = want;
        return p;
    endfunction

    // table write, or scan of the mirror table and the words that the line yields
    task automatic mirror_request(input sse_pkg::t_in_item w);
        int          wy, sx, start, offset, stop, count, top;
        int          kept [$];
        logic [31:0] addr;
        if (w.req_type == sse_pkg::REQ_WRITE) begin
            sprite_copy[w.entry_index].x      = w.entry_x;
            sprite_copy[w.entry_index].y      = w.entry_y;
            sprite_copy[w.entry_index].height = w.entry_height;
            sprite_copy[w.entry_index].base   = w.entry_base;
            sprite_shown[w.entry_index]       = w.entry_enable;
        end else begin
            wy = int'(w.line_y) + int'(scroll_y_copy);
            for (int i = 0; i < TABLE_DEPTH && kept.size() < LINE_LIMIT; i++) begin
                top = int'(sprite_copy[i].y);
                if (sprite_shown[i] && top <= wy && wy < top + int'(sprite_copy[i].height))
                    kept.push_back(i);
            end
            if (kept.size() == 0)
                line_results.push_back(make_result('0, 0, 0, 0, 0, 1'b1, 1'b1));
            // highest kept index first, lowest one carries last
            for (int k = kept.size() - 1; k >= 0; k--) begin
                addr   = 32'(sprite_copy[kept[k]].base)
                         + 32'((wy - int'(sprite_copy[kept[k]].y)) * SPRITE_W);
                sx     = int'(sprite_copy[kept[k]].x) - int'(scroll_x_copy);
                offset = (sx < 0) ? -sx : 0;
                start  = (sx < 0) ? 0 : sx;
                stop   = (sx + SPRITE_W > SCREEN_W) ? SCREEN_W : sx + SPRITE_W;
                count  = stop - start;
                if (count <= 0) begin
                    count  = 0;
                    start  = 0;
                    offset = 0;
                end
                line_results.push_back(make_result(addr[23:0], start, offset, count, kept[k],
                                                   1'b0, k == 0));
            end
        end
    endtask

    // offer one request word, with random gaps before it
    task automatic offer_word(input sse_pkg::t_in_item w, input bit typed,
                              input sse_pkg::t_out_item want);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push    <= 1'b1;
        in_word <= w;
        do @(posedge i_clk); while (full);
        n_requests++;
        if (w.req_type == sse_pkg::REQ_LINE)
            n_lines++;
        if (typed)
            line_results.push_back(want);
        else
            mirror_request(w);
    endtask

    task automatic set_register(input logic [sse_pkg::CFG_IDX_W-1:0] idx,
                                input logic [sse_pkg::COORD_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            sse_pkg::CFG_SCROLL_X: scroll_x_copy = value;
            sse_pkg::CFG_SCROLL_Y: scroll_y_copy = value;
            default: ;
        endcase
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering, wait for every predicted word, then let trailing writes finish
    task automatic drain_and_rest();
        @(negedge i_clk);
        push <= 1'b0;
        while (line_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // sprites placed around one world line, then requests for that line or the one below it
    task automatic play_scene(input int sprites, inout int sent);
        int                max_line, line, wy, h, r, top;
        sse_pkg::t_in_item w;
        max_line = 4095 + 254 - int'(scroll_y_copy);
        if (max_line > 1023)
            max_line = 1023;
        line = $urandom_range(0, max_line);
        wy   = line + int'(scroll_y_copy);
        repeat (sprites) begin
            w          = noise_word();
            w.req_type = sse_pkg::REQ_WRITE;
            h          = $urandom_range(1, 255);
            r          = $urandom_range(0, (h - 1 < wy) ? h - 1 : wy);
            top        = wy - r;
            if (top > 4095) begin
                top = 4095;
                if (h <= wy - 4095)
                    h = wy - 4095 + 1;
            end
            w.entry_y      = 12'(top);
            w.entry_height = 8'(h);
            w.entry_x      = 12'(int'(scroll_x_copy) + $urandom_range(0, 360) - 20);
            w.entry_enable = ($urandom_range(0, 9) != 0);
            offer_word(w, 1'b0, '0);
            sent++;
        end
        repeat ($urandom_range(1, 2)) begin
            w          = noise_word();
            w.req_type = sse_pkg::REQ_LINE;
            w.line_y   = 10'(line + $urandom_range(0, 1));
            offer_word(w, 1'b0, '0);
            sent++;
        end
    endtask

    task automatic run_phase(input logic [sse_pkg::COORD_W-1:0] sx,
                             input logic [sse_pkg::COORD_W-1:0] sy,
                             input int send_pct, input int recv_pct, input bit squeeze,
                             input int budget);
        int                sent, pick;
        sse_pkg::t_in_item w;
        set_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 12'($urandom));
        set_register(sse_pkg::CFG_SCROLL_X, sx);
        set_register(sse_pkg::CFG_SCROLL_Y, sy);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        if (squeeze)
            hold_req = 1'b1;
        sent = 0;
        // crowded line to push past the per-line limit
        play_scene(30, sent);
        while (sent < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                play_scene($urandom_range(1, 8), sent);
            end else begin
                w          = noise_word();
                w.req_type = (pick < 82) ? sse_pkg::REQ_WRITE : sse_pkg::REQ_LINE;
                offer_word(w, 1'b0, '0);
                sent++;
            end
        end
        drain_and_rest();
    endtask

    // result side: random pops, one long hold-off on request
    initial begin : result_side
        int                 hold_left;
        bit                 hold_taken;
        sse_pkg::t_out_item want;
        hold_left  = 0;
        hold_taken = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
            @(posedge i_clk);
            if (pop && !empty) begin
                if (line_results.size() == 0) begin
                    note_mismatch($sformatf("unexpected result word 0x%0h", result_word));
                end else begin
                    want = line_results.pop_front();
                    compare_field("row_address", result_word.row_address, want.row_address);
                    compare_field("screen_start", result_word.screen_start, want.screen_start);
                    compare_field("pixel_offset", result_word.pixel_offset, want.pixel_offset);
                    compare_field("pixel_count", result_word.pixel_count, want.pixel_count);
                    compare_field("sprite_number", result_word.sprite_number,
                                  want.sprite_number);
                    compare_field("none_active", result_word.none_active, want.none_active);
                    compare_field("last", result_word.last, want.last);
                end
                n_checked++;
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("scanline_sprite_evaluator_core_test: errors");
            $finish;
        end
    end

    initial begin : stimulus
        t_probe             probes [$];
        sse_pkg::t_out_item no_sprite;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            sprite_copy[i]  = '0;
            sprite_shown[i] = 1'b0;
        end
        no_sprite = make_result('0, 0, 0, 0, 0, 1'b1, 1'b1);

        // reset
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every register once, and one unused index with all ones
        set_register(CFG_SPARE_B, 12'hFFF);
        set_register(sse_pkg::CFG_SCROLL_X, 12'd0);
        set_register(sse_pkg::CFG_SCROLL_Y, 12'd0);

        // directed rows at zero scroll
        probes.push_back(probe(line_request(0), 1'b1, no_sprite));
        probes.push_back(probe(line_request(1023), 1'b1, no_sprite));
        probes.push_back(probe(sprite_write(0, 0, 0, 0, 1'b1, 0), 1'b0, '0));
        probes.push_back(probe(line_request(0), 1'b1, no_sprite));
        probes.push_back(probe(sprite_write(127, 4095, 0, 255, 1'b1, 20'hFFFFF), 1'b0, '0));
        probes.push_back(probe(line_request(0), 1'b1,
                               make_result(24'h0FFFFF, 0, 0, 0, 127, 1'b0, 1'b1)));
        probes.push_back(probe(sprite_write(1, 0, 0, 16, 1'b1, 20'h00100), 1'b0, '0));
        probes.push_back(probe(sprite_write(2, 310, 4, 8, 1'b1, 20'h12345), 1'b0, '0));
        probes.push_back(probe(sprite_write(3, 100, 0, 255, 1'b0, 20'h0ABCD), 1'b0, '0));
        probes.push_back(probe(sprite_write(4, 304, 0, 255, 1'b1, 0), 1'b0, '0));
        probes.push_back(probe(sprite_write(5, 320, 0, 255, 1'b1, 20'h55555), 1'b0, '0));
        probes.push_back(probe(line_request(5), 1'b0, '0));
        probes.push_back(probe(line_request(11), 1'b0, '0));
        probes.push_back(probe(line_request(12), 1'b0, '0));
        probes.push_back(probe(line_request(1023), 1'b1, no_sprite));
        probes.push_back(probe(sprite_write(126, 4095, 4095, 255, 1'b1, 0), 1'b0, '0));
        probes.push_back(probe(sprite_write(0, 4095, 4095, 255, 1'b0, 20'hFFFFF), 1'b0, '0));
        probes.push_back(probe(line_request(200), 1'b0, '0));
        foreach (probes[i])
            offer_word(probes[i].req, probes[i].typed, probes[i].want);
        drain_and_rest();

        // random phases: sender light and receiver heavy idling, then swapped, then none
        run_phase(12'd40, 12'd300, 19, 69, 1'b0, 42);
        run_phase(12'hFFF, 12'hFFF, 69, 19, 1'b0, 42);
        run_phase(12'($urandom), 12'($urandom), 0, 0, 1'b1, 42);
        run_phase(12'd0, 12'd0, 0, 0, 1'b0, 42);

        $display("covered %0d request words (%0d line requests) and %0d result words",
                 n_requests, n_lines, n_checked);
        $display("across %0d register writes, scroll extremes and a long result-side stall",
                 n_cfg);
        if (errors == 0)
            $display("scanline_sprite_evaluator_core_test: clean");
        else
            $display("scanline_sprite_evaluator_core_test: errors");
        $finish;
    end

endmodule

FILE: sim.f
design/sse_pkg.sv
design/sse_fifo.sv
design/sse_front.sv
design/sse_back.sv
design/scanline_sprite_evaluator_core.sv
tb/scanline_sprite_evaluator_core_test.sv
